/* src/sfl_pkg.sv */
// ----------------------------------------------------------------------------
// Slot free-list allocator package
// Sizes, command codes and error codes used by the allocator.
// ----------------------------------------------------------------------------
package sfl_pkg;

   // Number of slots handed out by the allocator.
   localparam int QUEUE_DEPTH = 64;

   // Widths fixed by the command and result formats.
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;
   localparam int MISS_W  = 32;

   // Ring and busy-table addressing.
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_RESET   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_RANGE = 2'd2,
      ERR_IDLE  = 2'd3
   } err_type;

endpackage

/* src/sfl_ram.sv */
// ----------------------------------------------------------------------------
// Slot free-list RAM
// One write port, one registered read port, and a valid bit per entry so
// that the whole table can be invalidated at once.
// ----------------------------------------------------------------------------
module sfl_ram #(
   parameter int DATA_W = 6,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   output logic              rd_valid
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // An entry that was never written since the last clear reads as invalid.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

/* src/slot_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// Slot free-list allocator
// Hands out slot indices from a circular free list kept in RAM and takes them
// back, with a busy table per slot and a saturating miss counter.
//
//   Channel   Ports                                  Direction  Handshake
//   command   req_command, req_slot_index            in         start & !busy
//   result    rsp_ok, rsp_slot, rsp_error_code,      out        rsp_valid strobe
//             rsp_free_count, rsp_miss_count
//
// Each command runs through ST_IDLE and ST_EXEC: the accepting edge starts the RAM
// reads of the ring head and the busy bit, and the edge that leaves ST_EXEC
// writes back and launches the result beat, as the RAMs have registered reads.
// busy is high for the one cycle between those edges; a new command may be
// accepted in the cycle in which the previous result beat is shown.
// Reset (and the reset command) frees every slot at once by invalidating both
// RAMs; no clearing pass is needed. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module slot_free_list_allocator import sfl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [SLOT_W-1:0]  req_slot_index,
   output logic               rsp_valid,
   output logic               rsp_ok,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [1:0]         rsp_error_code,
   output logic [COUNT_W-1:0] rsp_free_count,
   output logic [MISS_W-1:0]  rsp_miss_count
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   localparam logic [IDX_W:0] DEPTH_SUM = (IDX_W+1)'(QUEUE_DEPTH);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [MISS_W-1:0]  miss_ff, miss_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   err_type            rsp_err_ff, rsp_err_in;

   logic               accept;
   logic               exec;

   logic               ring_wr_en;
   logic [IDX_W-1:0]   ring_wr_addr;
   logic [SLOT_W-1:0]  ring_rd_data;
   logic               ring_rd_valid;
   logic               busy_wr_en;
   logic [IDX_W-1:0]   busy_wr_addr;
   logic               busy_wr_data;
   logic               busy_rd_data;
   logic               busy_rd_valid;
   logic               tbl_clear;

   logic [SLOT_W-1:0]  head_slot;
   logic               slot_in_use;
   logic [IDX_W:0]     tail_sum;
   logic [IDX_W-1:0]   tail;

   assign accept = start && (state_ff == ST_IDLE);
   assign exec   = (state_ff == ST_EXEC);

   // Free ring: entry i holds i until it is first overwritten.
   sfl_ram #(
      .DATA_W (SLOT_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .clear    (tbl_clear),
      .wr_en    (ring_wr_en),
      .wr_addr  (ring_wr_addr),
      .wr_data  (idx_ff),
      .rd_en    (accept),
      .rd_addr  (head_ff),
      .rd_data  (ring_rd_data),
      .rd_valid (ring_rd_valid)
   );

   // Busy table: an entry never written since the last clear means free.
   sfl_ram #(
      .DATA_W (1),
      .DEPTH  (QUEUE_DEPTH)
   ) u_busy (
      .clock    (clock),
      .reset    (reset),
      .clear    (tbl_clear),
      .wr_en    (busy_wr_en),
      .wr_addr  (busy_wr_addr),
      .wr_data  (busy_wr_data),
      .rd_en    (accept),
      .rd_addr  (IDX_W'(req_slot_index)),
      .rd_data  (busy_rd_data),
      .rd_valid (busy_rd_valid)
   );

   // The head address does not move between the read and the write back.
   assign head_slot   = ring_rd_valid ? ring_rd_data : SLOT_W'(head_ff);
   assign slot_in_use = busy_rd_valid && busy_rd_data;

   assign tail_sum = (IDX_W+1)'(head_ff) + (IDX_W+1)'(count_ff);
   assign tail     = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                             : IDX_W'(tail_sum);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      miss_in      = miss_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_err_in   = rsp_err_ff;
      ring_wr_en   = 1'b0;
      ring_wr_addr = tail;
      busy_wr_en   = 1'b0;
      busy_wr_addr = IDX_W'(idx_ff);
      busy_wr_data = 1'b0;
      tbl_clear    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b0;
            rsp_slot_in  = '0;
            rsp_err_in   = ERR_NONE;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (count_ff == '0) begin
                     rsp_err_in = ERR_EMPTY;
                     if (miss_ff != '1) begin
                        miss_in = miss_ff + 1'b1;
                     end
                  end else begin
                     rsp_ok_in    = 1'b1;
                     rsp_slot_in  = head_slot;
                     head_in      = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : head_ff + 1'b1;
                     count_in     = count_ff - 1'b1;
                     busy_wr_en   = 1'b1;
                     busy_wr_addr = IDX_W'(head_slot);
                     busy_wr_data = 1'b1;
                  end
               end
               CMD_RELEASE: begin
                  if (COUNT_W'(idx_ff) >= COUNT_W'(QUEUE_DEPTH)) begin
                     rsp_err_in = ERR_RANGE;
                  end else if (!slot_in_use || count_ff >= COUNT_W'(QUEUE_DEPTH)) begin
                     rsp_err_in = ERR_IDLE;
                  end else begin
                     rsp_ok_in  = 1'b1;
                     ring_wr_en = 1'b1;
                     busy_wr_en = 1'b1;
                     count_in   = count_ff + 1'b1;
                  end
               end
               CMD_PEEK: begin
                  if (count_ff == '0) begin
                     rsp_err_in = ERR_EMPTY;
                  end else begin
                     rsp_ok_in   = 1'b1;
                     rsp_slot_in = head_slot;
                  end
               end
               CMD_RESET: begin
                  rsp_ok_in = 1'b1;
                  tbl_clear = 1'b1;
                  head_in   = '0;
                  count_in  = COUNT_W'(QUEUE_DEPTH);
               end
               default: begin
                  rsp_ok_in = 1'b0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= COUNT_W'(QUEUE_DEPTH);
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ok_ff    <= 1'b0;
         rsp_slot_ff  <= '0;
         rsp_err_ff   <= ERR_NONE;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ok_ff    <= rsp_ok_in;
         rsp_slot_ff  <= rsp_slot_in;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   // Command capture carries no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_command);
         idx_ff <= req_slot_index;
      end
   end

   assign busy           = exec;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_free_count = count_ff;
   assign rsp_miss_count = miss_ff;

   a_beat_follows_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EXEC))
      else $error("result beat without a command in flight");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("free count exceeds the number of slots");

   a_refused_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_slot == '0 && rsp_error_code != ERR_NONE))
      else $error("refused command reports a slot or no error");

   a_alloc_takes_one: assert property (@(posedge clock) disable iff (reset)
      (exec && cmd_ff == CMD_ALLOC && count_ff != '0) |=>
         (rsp_ok && rsp_free_count == $past(count_ff) - 1'b1))
      else $error("allocation did not take exactly one slot");

endmodule
